@@ hdl/cdrg_pkg.sv @@
// Shared constants, codes and interface structs for the chunk DC removal unit.
package cdrg_pkg;

    localparam int CHUNK_MAX = 64;
    localparam int CHUNK_AW  = $clog2(CHUNK_MAX);
    localparam int CNT_W     = $clog2(CHUNK_MAX + 1);
    localparam int NUM_BANKS = 2;
    localparam int RAM_AW    = CHUNK_AW + $clog2(NUM_BANKS);
    localparam int RAM_DEPTH = NUM_BANKS * CHUNK_MAX;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 22;
    localparam int GAIN_W    = 12;
    localparam int THR_W     = 16;
    localparam int CLIP_W    = 32;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + GAIN_W + 1;
    localparam int GAIN_FRAC = 8;
    localparam int SHV_W     = PROD_W - GAIN_FRAC;

    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd32000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESHOLD = 1'b1;

    typedef struct packed {
        logic                bank;
        logic [CNT_W-1:0]    n;
        logic [SAMPLE_W-1:0] mean;
        logic                clear;
    } t_desc;

    typedef struct packed {
        logic                en;
        logic [RAM_AW-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } t_ram_rd;

endpackage

@@ hdl/cdrg_div.sv @@
// Iterative restoring divider for the chunk mean, one quotient bit per cycle.
module cdrg_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [cdrg_pkg::SUM_W-1:0]     i_dividend,
    input  logic        [cdrg_pkg::CNT_W-1:0]     i_divisor,
    output logic                                  o_done,
    output logic        [cdrg_pkg::SAMPLE_W-1:0]  o_quot
);
    import cdrg_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [STEP_W-1:0]   r_step;

    logic [CNT_W:0]      trial;
    logic                ge;
    logic [SAMPLE_W-1:0] mag;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
                r_quo  <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
            end else if (r_busy) begin
                r_rem  <= ge ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign mag    = r_quo[SAMPLE_W-1:0];
    assign o_quot = r_neg ? SAMPLE_W'(-mag) : mag;
    assign o_done = r_done;

endmodule

@@ hdl/cdrg_ram.sv @@
// Two-bank chunk sample store, one write port and one registered read port.
module cdrg_ram (
    input  logic                            i_clk,
    input  cdrg_pkg::t_ram_wr               i_wr,
    input  cdrg_pkg::t_ram_rd               i_rd,
    output logic [cdrg_pkg::SAMPLE_W-1:0]   o_rdata
);
    import cdrg_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [RAM_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cdrg_front.sv @@
// Front end: sample loading, chunk sum, mean division and chunk descriptor queue.
module cdrg_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic signed [cdrg_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_chunk_last,
    input  logic                                 i_stats_clear,
    input  logic                                 i_desc_pop,
    output logic                                 o_full,
    output logic                                 o_desc_valid,
    output cdrg_pkg::t_desc                      o_desc,
    output cdrg_pkg::t_ram_wr                    o_ram_wr
);
    import cdrg_pkg::*;

    logic                    r_busy;
    logic                    r_wbank;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_n;
    logic                    r_clear;

    t_desc                   r_q [NUM_BANKS];
    logic                    r_q_wp;
    logic                    r_q_rp;
    logic [1:0]              r_q_cnt;

    logic                    accept;
    logic                    close;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] sum_inc;
    logic                    div_done;
    logic [SAMPLE_W-1:0]     div_quot;
    logic                    q_pop;

    assign o_full  = r_busy || (r_q_cnt == 2'(NUM_BANKS));
    assign accept  = i_push && !o_full;
    assign cnt_inc = r_cnt + 1'b1;
    assign sum_inc = r_sum + SUM_W'(i_sample_in);
    assign close   = i_chunk_last || (cnt_inc == CNT_W'(CHUNK_MAX));
    assign q_pop   = i_desc_pop && (r_q_cnt != 2'd0);

    assign o_ram_wr.en   = accept;
    assign o_ram_wr.addr = {r_wbank, r_cnt[CHUNK_AW-1:0]};
    assign o_ram_wr.data = i_sample_in;

    cdrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && close),
        .i_dividend (sum_inc),
        .i_divisor  (cnt_inc),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_wbank <= 1'b0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            if (accept) begin
                if (close) begin
                    r_busy  <= 1'b1;
                    r_n     <= cnt_inc;
                    r_clear <= i_stats_clear;
                    r_cnt   <= '0;
                    r_sum   <= '0;
                end else begin
                    r_cnt <= cnt_inc;
                    r_sum <= sum_inc;
                end
            end
            if (div_done) begin
                r_busy  <= 1'b0;
                r_wbank <= !r_wbank;
            end
        end
    end

    // hold one descriptor per loaded bank until the back end drains it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (div_done) begin
                r_q[r_q_wp] <= '{bank: r_wbank, n: r_n, mean: div_quot, clear: r_clear};
                r_q_wp      <= !r_q_wp;
            end
            if (q_pop) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + 2'(div_done) - 2'(q_pop);
        end
    end

    assign o_desc_valid = r_q_cnt != 2'd0;
    assign o_desc       = r_q[r_q_rp];

endmodule

@@ hdl/cdrg_back.sv @@
// Back end: per-sample mean removal, gain, saturation, statistics and output word.
module cdrg_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_desc_valid,
    input  cdrg_pkg::t_desc                     i_desc,
    input  logic [cdrg_pkg::SAMPLE_W-1:0]       i_rdata,
    input  logic [cdrg_pkg::GAIN_W-1:0]         i_gain,
    input  logic [cdrg_pkg::THR_W-1:0]          i_thresh,
    input  logic                                i_pop,
    output logic                                o_desc_pop,
    output cdrg_pkg::t_ram_rd                   o_ram_rd,
    output logic                                o_empty,
    output logic signed [cdrg_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_last_out,
    output logic [cdrg_pkg::SAMPLE_W-1:0]       o_peak_level,
    output logic [cdrg_pkg::CLIP_W-1:0]         o_clip_count
);
    import cdrg_pkg::*;

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_READ = 4'b0010,
        BS_MUL  = 4'b0100,
        BS_EMIT = 4'b1000
    } t_bstate;

    t_bstate                  r_state;
    logic [CHUNK_AW-1:0]      r_idx;
    logic signed [PROD_W-1:0] r_prod;
    logic [SAMPLE_W-1:0]      r_peak;
    logic [CLIP_W-1:0]        r_clip;
    logic                     r_ov;
    logic [SAMPLE_W-1:0]      r_sample;
    logic                     r_last;
    logic [SAMPLE_W-1:0]      r_peak_out;
    logic [CLIP_W-1:0]        r_clip_out;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SHV_W-1:0]    shv;
    logic signed [SAMPLE_W-1:0] sat;
    logic [SAMPLE_W:0]          mag17;
    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W-1:0]        peak_nx;
    logic [CLIP_W-1:0]          clip_nx;
    logic                       is_last;
    logic                       commit;

    assign diff   = $signed({i_rdata[SAMPLE_W-1], i_rdata})
                  - $signed({i_desc.mean[SAMPLE_W-1], i_desc.mean});
    assign gain_s = $signed({1'b0, i_gain});
    assign prod   = diff * gain_s;
    assign shv    = r_prod[PROD_W-1:GAIN_FRAC];

    always_comb begin
        priority if (shv > SHV_W'(SAT_HI)) begin
            sat = SAT_HI;
        end else if (shv < SHV_W'(SAT_LO)) begin
            sat = SAT_LO;
        end else begin
            sat = shv[SAMPLE_W-1:0];
        end
    end

    assign mag17   = sat[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sat[SAMPLE_W-1], sat}))
                                     : {1'b0, sat};
    assign mag     = mag17[SAMPLE_W-1:0];
    assign peak_nx = (mag > r_peak) ? mag : r_peak;
    assign clip_nx = ((mag >= i_thresh) && (r_clip != '1)) ? r_clip + 1'b1 : r_clip;
    assign is_last = (CNT_W'(r_idx) + 1'b1) == i_desc.n;
    assign commit  = (r_state == BS_EMIT) && (!r_ov || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_idx   <= '0;
            r_peak  <= '0;
            r_clip  <= '0;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                BS_IDLE: begin
                    r_idx <= '0;
                    if (i_desc_valid) begin
                        r_state <= BS_READ;
                    end
                end
                BS_READ: begin
                    r_state <= BS_MUL;
                end
                BS_MUL: begin
                    r_prod  <= prod;
                    r_state <= BS_EMIT;
                end
                BS_EMIT: begin
                    if (commit) begin
                        if (is_last) begin
                            r_state <= BS_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= BS_READ;
                        end
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase

            if (commit) begin
                r_ov       <= 1'b1;
                r_sample   <= sat;
                r_last     <= is_last;
                r_peak_out <= peak_nx;
                r_clip_out <= clip_nx;
                r_peak     <= (is_last && i_desc.clear) ? '0 : peak_nx;
                r_clip     <= (is_last && i_desc.clear) ? '0 : clip_nx;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_desc_pop    = commit && is_last;
    assign o_ram_rd.en   = r_state == BS_READ;
    assign o_ram_rd.addr = {i_desc.bank, r_idx};
    assign o_empty       = !r_ov;
    assign o_sample_out  = r_sample;
    assign o_last_out    = r_last;
    assign o_peak_level  = r_peak_out;
    assign o_clip_count  = r_clip_out;

endmodule

@@ hdl/chunk_dc_removal_gain_clip_unit.sv @@
// Top level of the chunk DC removal, gain and clip unit.
//
// Channel   Direction  Handshake           Word
// input     in         push / full         i_sample_in, i_chunk_last, i_stats_clear
// result    out        pop / empty         o_sample_out, o_last_out, o_peak_level,
//                                          o_clip_count
// config    in         i_cfg_wr_en         i_cfg_index, i_cfg_wdata
//
// Loading accepts one sample per cycle while full is low. The closing
// sample starts a 22-step serial divide for the chunk mean; full stays high
// while it runs. The back end takes each output sample through three steps
// (store read, multiply, saturate) before the next, and via idle between chunks.
// Pop held low while a word is waiting stalls the back end in place.
// Two store banks let the next chunk load while the previous one drains.
// Reset is synchronous and clears all control state and statistics.
module chunk_dc_removal_gain_clip_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [cdrg_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                  i_chunk_last,
    input  logic                                  i_stats_clear,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [cdrg_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out,
    output logic        [cdrg_pkg::SAMPLE_W-1:0]  o_peak_level,
    output logic        [cdrg_pkg::CLIP_W-1:0]    o_clip_count,
    input  logic                                  i_cfg_wr_en,
    input  logic        [cdrg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [cdrg_pkg::THR_W-1:0]     i_cfg_wdata
);
    import cdrg_pkg::*;

    logic [GAIN_W-1:0]   r_gain;
    logic [THR_W-1:0]    r_thresh;

    logic                desc_valid;
    logic                desc_pop;
    t_desc               desc;
    t_ram_wr             ram_wr;
    t_ram_rd             ram_rd;
    logic [SAMPLE_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_thresh <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_GAIN_Q8:        r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_CLIP_THRESHOLD: r_thresh <= i_cfg_wdata;
                default:            r_gain   <= r_gain;
            endcase
        end
    end

    cdrg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_sample_in   (i_sample_in),
        .i_chunk_last  (i_chunk_last),
        .i_stats_clear (i_stats_clear),
        .i_desc_pop    (desc_pop),
        .o_full        (full),
        .o_desc_valid  (desc_valid),
        .o_desc        (desc),
        .o_ram_wr      (ram_wr)
    );

    cdrg_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_rd    (ram_rd),
        .o_rdata (ram_rdata)
    );

    cdrg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .i_rdata      (ram_rdata),
        .i_gain       (r_gain),
        .i_thresh     (r_thresh),
        .i_pop        (pop),
        .o_desc_pop   (desc_pop),
        .o_ram_rd     (ram_rd),
        .o_empty      (empty),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out),
        .o_peak_level (o_peak_level),
        .o_clip_count (o_clip_count)
    );

endmodule

@@ hdl/cdrg_checker.sv @@
// Port-level checker for the chunk DC removal unit, bound to the top level.
module cdrg_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  full,
    input logic                                  empty,
    input logic                                  pop,
    input logic signed [cdrg_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic                                  o_last_out,
    input logic        [cdrg_pkg::SAMPLE_W-1:0]  o_peak_level,
    input logic        [cdrg_pkg::CLIP_W-1:0]    o_clip_count
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue flags not cleared by reset");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_sample_out) && $stable(o_last_out))
        else $error("stalled output word changed");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_peak_level <= 16'd32768)
        else $error("peak level out of range");

    a_stats_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_out) |=>
            empty || ((o_clip_count >= $past(o_clip_count))
                      && (o_peak_level >= $past(o_peak_level))))
        else $error("statistics dropped inside a chunk");

endmodule

bind chunk_dc_removal_gain_clip_unit cdrg_checker u_cdrg_checker (.*);

@@ dv/cdrg_chunk_check.sv @@
// Checker for the chunk DC removal unit: predicts every output word and compares it.
`timescale 1ns / 100ps
module cdrg_chunk_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    input  logic                                  full,
    input  logic signed [cdrg_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                  i_chunk_last,
    input  logic                                  i_stats_clear,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic signed [cdrg_pkg::SAMPLE_W-1:0]  o_sample_out,
    input  logic                                  o_last_out,
    input  logic        [cdrg_pkg::SAMPLE_W-1:0]  o_peak_level,
    input  logic        [cdrg_pkg::CLIP_W-1:0]    o_clip_count,
    input  logic                                  i_cfg_wr_en,
    input  logic        [cdrg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [cdrg_pkg::THR_W-1:0]     i_cfg_wdata,
    output int                                    o_errors,
    output int                                    o_pending
);
    import cdrg_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic        [SAMPLE_W-1:0] peak;
        logic        [CLIP_W-1:0]   clips;
    } t_out_word;

    t_out_word                  out_words_due[$];
    t_out_word                  want;
    logic signed [SAMPLE_W-1:0] chunk_mem [CHUNK_MAX];
    logic signed [SUM_W-1:0]    chunk_sum;
    int                         chunk_len;
    logic        [SAMPLE_W-1:0] peak_mag;
    logic        [CLIP_W-1:0]   clip_total;
    logic        [GAIN_W-1:0]   gain_q8;
    logic        [THR_W-1:0]    clip_thr;
    int                         err_cnt = 0;

    task automatic check_field(input string name, input longint exp_val, input longint got_val);
        if (exp_val != got_val) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
            err_cnt++;
        end
    endtask

    // compute the mean, then emit one word per stored sample in arrival order
    task automatic close_chunk(input logic clear_stats);
        int        mean;
        int        val;
        int        mag;
        int        k;
        t_out_word w;
        mean = int'(chunk_sum) / chunk_len;
        for (k = 0; k < chunk_len; k++) begin
            val = (int'(chunk_mem[k]) - mean) * int'(gain_q8);
            val = val >>> GAIN_FRAC;
            if (val > SAT_HI) begin
                val = SAT_HI;
            end else if (val < SAT_LO) begin
                val = SAT_LO;
            end
            mag = (val < 0) ? -val : val;
            if (mag > int'(peak_mag)) begin
                peak_mag = mag[SAMPLE_W-1:0];
            end
            if (mag >= int'(clip_thr) && clip_total != '1) begin
                clip_total++;
            end
            w.sample = val[SAMPLE_W-1:0];
            w.last   = (k == chunk_len - 1);
            w.peak   = peak_mag;
            w.clips  = clip_total;
            out_words_due.push_back(w);
        end
        if (clear_stats) begin
            peak_mag   = '0;
            clip_total = '0;
        end
        chunk_sum = '0;
        chunk_len = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_words_due.delete();
            chunk_sum  = '0;
            chunk_len  = 0;
            peak_mag   = '0;
            clip_total = '0;
            gain_q8    = GAIN_RESET;
            clip_thr   = THR_RESET;
        end else begin
            if (pop && !empty) begin
                if (out_words_due.size() == 0) begin
                    $display("%0t ns: output word with none expected: sample %0d last %0b",
                             $time, o_sample_out, o_last_out);
                    err_cnt++;
                end else begin
                    want = out_words_due.pop_front();
                    check_field("sample_out", want.sample, o_sample_out);
                    check_field("last_out", want.last, o_last_out);
                    check_field("peak_level", want.peak, o_peak_level);
                    check_field("clip_count", want.clips, o_clip_count);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_GAIN_Q8:        gain_q8  = i_cfg_wdata[GAIN_W-1:0];
                    CFG_CLIP_THRESHOLD: clip_thr = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (push && !full) begin
                if (chunk_len < CHUNK_MAX) begin
                    chunk_mem[chunk_len] = i_sample_in;
                    chunk_len++;
                    chunk_sum += SUM_W'(i_sample_in);
                end
                if (i_chunk_last || chunk_len == CHUNK_MAX) begin
                    close_chunk(i_stats_clear);
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= out_words_due.size();
    end

endmodule

@@ dv/tb_chunk_dc_removal_gain_clip_unit.sv @@
// Testbench top for the chunk DC removal unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_chunk_dc_removal_gain_clip_unit;
    import cdrg_pkg::*;

    localparam int IDLE_PCT      = 23;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 52;

    logic                        i_clk;
    logic                        i_rst_n       = 1'b0;
    logic                        push          = 1'b0;
    logic                        full;
    logic signed [SAMPLE_W-1:0]  i_sample_in   = '0;
    logic                        i_chunk_last  = 1'b0;
    logic                        i_stats_clear = 1'b0;
    logic                        empty;
    logic                        pop           = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        o_last_out;
    logic        [SAMPLE_W-1:0]  o_peak_level;
    logic        [CLIP_W-1:0]    o_clip_count;
    logic                        i_cfg_wr_en   = 1'b0;
    logic        [CFG_IDX_W-1:0] i_cfg_index   = CFG_GAIN_Q8;
    logic        [THR_W-1:0]     i_cfg_wdata   = '0;

    int fail_count;
    int words_due;
    int stall_cycles = 0;
    int words_sent   = 0;
    bit gaps_on      = 1'b1;

    chunk_dc_removal_gain_clip_unit dut (.*);

    cdrg_chunk_check u_check (.*, .o_errors(fail_count), .o_pending(words_due));

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        pop <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic last,
                             input logic clr);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_sample_in   <= smp;
        i_chunk_last  <= last;
        i_stats_clear <= clr;
        do @(posedge i_clk); while (full);
        words_sent++;
    endtask

    task automatic send_chunk(input int len, input bit mark_last, input bit close_clear);
        logic signed [SAMPLE_W-1:0] smp;
        int                         k;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0:       smp = SAT_HI;
                1:       smp = SAT_LO;
                2, 3, 4: smp = SAMPLE_W'($urandom_range(1000) - 500);
                default: smp = SAMPLE_W'($urandom());
            endcase
            if (k == len - 1) begin
                send_word(smp, mark_last, close_clear);
            end else begin
                send_word(smp, 1'b0, $urandom_range(4) == 0);
            end
        end
    endtask

    // hold off input until every predicted word is out, then let the unit settle
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [THR_W-1:0] thr);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_GAIN_Q8;
        i_cfg_wdata <= THR_W'(gain);
        @(posedge i_clk);
        i_cfg_index <= CFG_CLIP_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int base;
        int p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unity gain, default threshold
        send_word(SAT_HI, 1'b1, 1'b0);
        send_word(SAT_LO, 1'b1, 1'b0);
        send_word(SAT_HI, 1'b0, 1'b0);
        send_word(SAT_LO, 1'b1, 1'b1);
        send_word(16'sd100, 1'b0, 1'b1);
        send_word(-16'sd100, 1'b1, 1'b0);
        send_word(16'sd0, 1'b0, 1'b0);
        send_word(16'sd1, 1'b0, 1'b0);
        send_word(-16'sd1, 1'b1, 1'b1);

        wait_drained();
        set_regs('1, '0);
        send_word(SAT_HI, 1'b0, 1'b0);
        send_word(SAT_LO, 1'b0, 1'b0);
        send_word(16'sd5, 1'b0, 1'b0);
        send_word(16'sd0, 1'b1, 1'b1);

        wait_drained();
        set_regs('0, '1);
        send_word(16'sd1234, 1'b0, 1'b0);
        send_word(-16'sd4321, 1'b1, 1'b0);

        wait_drained();
        set_regs(12'd1, 16'd32768);
        send_word(SAT_LO, 1'b0, 1'b0);
        send_word(SAT_LO, 1'b0, 1'b0);
        send_word(SAT_HI, 1'b1, 1'b1);

        base = words_sent;
        for (p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0:       set_regs(GAIN_W'($urandom_range(128, 512)),
                                  THR_W'($urandom_range(1000, 32768)));
                1:       set_regs('1, THR_W'($urandom_range(0, 65535)));
                2:       set_regs(GAIN_W'($urandom_range(0, 4095)), 16'd32768);
                default: set_regs(GAIN_W'($urandom_range(1, 1023)),
                                  THR_W'($urandom_range(0, 16000)));
            endcase
            gaps_on <= (p != 1);
            if (p == 0) begin
                send_chunk(CHUNK_MAX, 1'b0, 1'b1);
            end
            while (words_sent < base + (p + 1) * PHASE_WORDS) begin
                send_chunk(($urandom_range(9) == 0) ? int'($urandom_range(9, 24))
                                                    : int'($urandom_range(1, 8)),
                           1'b1, $urandom_range(9) < 3);
            end
        end

        wait_drained();
        if (fail_count == 0 && words_due == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
